/* design/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and decode functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    // One queue entry: up to three result items of one input item
    typedef struct packed {
        logic [23:0] data;      // first byte in bits 7:0
        logic [1:0]  count;     // number of result items, 1..3
        logic        has_data;  // 0 only for the empty end-of-text item
        logic        last;      // final item of the entry closes the string
    } b64d_entry_t;

    // Bit 6 set: not an alphabet character (includes '=')
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = {1'b0, 6'(c - CH_UPPER_A)};
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            r = {1'b0, 6'(c - CH_LOWER_A + LOWER_BASE)};
        end
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            r = {1'b0, 6'(c - CH_DIGIT_0 + DIGIT_BASE)};
        end
        else if (c == CH_PLUS)
        begin
            r = {1'b0, SEXT_PLUS};
        end
        else if (c == CH_SLASH)
        begin
            r = {1'b0, SEXT_SLASH};
        end
        return r;
    endfunction

    // Three held values (oldest highest) plus a fourth give three bytes
    function automatic logic [23:0] group_bytes(input logic [17:0] h, input logic [5:0] s);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        b0 = {h[17:12], h[11:10]};
        b1 = {h[9:6], h[5:2]};
        b2 = {h[1:0], s};
        return {b2, b1, b0};
    endfunction

endpackage

/* design/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets, keeps the partial group and
// pushes one queue entry for each character that yields result items.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        in_end,
    input  logic        full,
    output logic        push,
    output b64d_entry_t entry
);

    logic [17:0] hold_reg;
    logic [17:0] hold_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        halted_reg;
    logic        halted_next;

    logic [6:0]  sext;
    logic        accept;
    logic        emit_group;
    logic [17:0] upd_hold;
    logic [1:0]  upd_fill;
    logic        upd_halted;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign sext     = sextet_of(in_char);

    always_comb
    begin
        upd_hold   = hold_reg;
        upd_fill   = fill_reg;
        upd_halted = halted_reg;
        emit_group = 1'b0;
        if (!halted_reg)
        begin
            if (sext[6])
            begin
                upd_halted = 1'b1;
            end
            else if (fill_reg == 2'd3)
            begin
                emit_group = 1'b1;
                upd_hold   = '0;
                upd_fill   = 2'd0;
            end
            else
            begin
                upd_hold = {hold_reg[11:0], sext[5:0]};
                upd_fill = fill_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        entry.data     = '0;
        entry.count    = 2'd1;
        entry.has_data = 1'b1;
        entry.last     = in_end;
        if (emit_group)
        begin
            entry.data  = group_bytes(hold_reg, sext[5:0]);
            entry.count = 2'd3;
        end
        else if (upd_fill == 2'd3)
        begin
            // flush two bytes of a three-value group
            entry.data  = {8'h00, upd_hold[9:6], upd_hold[5:2],
                           upd_hold[17:12], upd_hold[11:10]};
            entry.count = 2'd2;
        end
        else if (upd_fill == 2'd2)
        begin
            entry.data  = {16'h0000, upd_hold[11:6], upd_hold[5:4]};
            entry.count = 2'd1;
        end
        else
        begin
            // end flag with nothing to flush: empty closing item
            entry.has_data = 1'b0;
        end
        push = accept && (emit_group || in_end);
    end

    always_comb
    begin
        hold_next   = hold_reg;
        fill_next   = fill_reg;
        halted_next = halted_reg;
        if (accept)
        begin
            if (in_end)
            begin
                hold_next   = '0;
                fill_next   = 2'd0;
                halted_next = 1'b0;
            end
            else
            begin
                hold_next   = upd_hold;
                fill_next   = upd_fill;
                halted_next = upd_halted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= '0;
            fill_reg   <= 2'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            hold_reg   <= hold_next;
            fill_reg   <= fill_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* design/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Small first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64d_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output b64d_entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Takes queue entries apart into single byte items and drives the output
// register of the master side.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  b64d_entry_t head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_byte_valid,
    output logic        out_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       bvalid_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    logic       load;
    logic       final_item;
    logic [7:0] sel_byte;

    assign load       = !empty && (!valid_reg || out_ready);
    assign final_item = (idx_reg == head.count - 2'd1);
    assign pop        = load && final_item;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.data[7:0];
            2'd1:    sel_byte = head.data[15:8];
            2'd2:    sel_byte = head.data[23:16];
            default: sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = final_item ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // hold payload while the sink stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= sel_byte;
            bvalid_reg <= head.has_data;
            last_reg   <= head.last && final_item;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_last       = last_reg;

endmodule

/* design/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 decoder: one encoded character in per item, decoded bytes out.
// ----------------------------------------------------------------------------
// The slave side accepts one character per cycle whenever the internal queue
// has room; the master side delivers one byte item per cycle while items are
// queued and the sink is ready. Bytes pass from front logic into the queue,
// then from the queue head into the output register. A fourth value of a
// group produces three items and the end flag one or two, all queued as one
// entry, so the input only stalls when the sink stalls long enough for
// QUEUE_DEPTH entries to pile up. On the end flag with nothing left to flush
// a single item with tuser low, tdata zero and tlast high closes the string.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast    // last_of_text
);

    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    b64d_entry_t q_in;
    b64d_entry_t q_head;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .in_end   (s_axis_tlast),
        .full     (q_full),
        .push     (q_push),
        .entry    (q_in)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (q_empty),
        .head           (q_head),
        .pop            (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_byte_valid (m_axis_tuser),
        .out_last       (m_axis_tlast)
    );

endmodule

/* design/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // stalled result item stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // an item without a byte only closes a string, and carries zero
    a_empty_item_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("empty item without end mark or with nonzero data");

    // input backs up only behind a waiting result item
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output item offered");

    // nothing pending right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output item offered out of reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

/* tb/base64_stream_decoder_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking stream test of the base64 decoder.
// ----------------------------------------------------------------------------
// Encoded strings go in one character per item: a short directed set first,
// then random strings. Most are well formed, with or without padding. Others
// are damaged, end on a lone value, or are plain noise. A local decoder
// predicts the byte items of every accepted character. The monitor checks
// each output item against the oldest prediction. Both sides idle at random,
// and one long output stall makes the input back up.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

    localparam int RANDOM_CHARS = 180;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 60;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_char_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } decoded_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_char
    logic       s_axis_tlast  = 1'b0;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tuser;            // [0] byte_valid
    logic       m_axis_tlast;            // last_of_text

    // Decoder state as predicted
    logic [17:0] held_sextets = '0;
    logic [1:0]  held_count   = '0;
    logic        text_halted  = 1'b0;

    text_char_t text_queue [$];
    decoded_t   expected_bytes [$];
    decoded_t   want_item;

    logic sink_hold = 1'b0;
    int   src_wait  = 0;
    int   src_burst = 0;
    int   snk_wait  = 0;
    int   snk_burst = 0;

    int   error_count        = 0;
    int   cycle_count        = 0;
    int   queued_chars       = 0;
    int   queued_strings     = 0;
    int   chars_accepted     = 0;
    int   strings_closed     = 0;
    int   bytes_checked      = 0;
    int   empty_ends         = 0;
    int   input_stall_cycles = 0;

    base64_stream_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bit 6 set: the character halts decoding
    function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'h40;
        if (ch >= "A" && ch <= "Z")
        begin
            t = ch - "A";
        end
        else if (ch >= "a" && ch <= "z")
        begin
            t = ch - "a" + 8'd26;
        end
        else if (ch >= "0" && ch <= "9")
        begin
            t = ch - "0" + 8'd52;
        end
        else if (ch == "+")
        begin
            t = 8'd62;
        end
        else if (ch == "/")
        begin
            t = 8'd63;
        end
        return t[6:0];
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = "A" + v;
        end
        else if (v < 6'd52)
        begin
            c = "a" + (v - 6'd26);
        end
        else if (v < 6'd62)
        begin
            c = "0" + (v - 6'd52);
        end
        else if (v == 6'd62)
        begin
            c = "+";
        end
        else
        begin
            c = "/";
        end
        return c;
    endfunction

    function automatic decoded_t make_item(input logic [7:0] d, input logic v, input logic l);
        decoded_t r;
        r.data  = d;
        r.valid = v;
        r.last  = l;
        return r;
    endfunction

    // Advance the predicted decoder by one character and queue its byte items
    task automatic decode_char(input logic [7:0] ch, input logic eot);
        decoded_t   res [3];
        int         n;
        int         i;
        logic [6:0] sx;
        n = 0;
        if (!text_halted)
        begin
            sx = char_to_sextet(ch);
            if (sx[6])
            begin
                text_halted = 1'b1;
            end
            else if (held_count == 2'd3)
            begin
                res[0] = make_item({held_sextets[17:12], held_sextets[11:10]}, 1'b1, 1'b0);
                res[1] = make_item({held_sextets[9:6], held_sextets[5:2]}, 1'b1, 1'b0);
                res[2] = make_item({held_sextets[1:0], sx[5:0]}, 1'b1, 1'b0);
                n = 3;
                held_sextets = '0;
                held_count   = '0;
            end
            else
            begin
                held_sextets = {held_sextets[11:0], sx[5:0]};
                held_count   = held_count + 2'd1;
            end
        end
        if (eot)
        begin
            if (held_count == 2'd2)
            begin
                res[n] = make_item({held_sextets[11:6], held_sextets[5:4]}, 1'b1, 1'b0);
                n = n + 1;
            end
            else if (held_count == 2'd3)
            begin
                res[n] = make_item({held_sextets[17:12], held_sextets[11:10]}, 1'b1, 1'b0);
                res[n + 1] = make_item({held_sextets[9:6], held_sextets[5:2]}, 1'b1, 1'b0);
                n = n + 2;
            end
            if (n == 0)
            begin
                res[0] = make_item(8'h00, 1'b0, 1'b1);
                n = 1;
            end
            else
            begin
                res[n - 1].last = 1'b1;
            end
            held_sextets = '0;
            held_count   = '0;
            text_halted  = 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            expected_bytes.insert(expected_bytes.size(), res[i]);
        end
    endtask

    task automatic queue_text(input logic [7:0] txt [$]);
        text_char_t tc;
        int         i;
        for (i = 0; i < txt.size(); i++)
        begin
            tc.ch  = txt[i];
            tc.eot = (i == txt.size() - 1);
            text_queue.insert(text_queue.size(), tc);
        end
        queued_chars   += txt.size();
        queued_strings += 1;
    endtask

    task automatic add_string(input string s);
        logic [7:0] txt [$];
        int         i;
        for (i = 0; i < s.len(); i++)
        begin
            txt.insert(txt.size(), s[i]);
        end
        queue_text(txt);
    endtask

    // Encode random bytes; optionally pad, damage one character, append junk
    // or end on a lone value
    task automatic add_encoded_text(input int nbytes, input bit pad, input bit damage,
                                    input int tail, input bit lone);
        logic [7:0]  txt [$];
        logic [23:0] grp;
        int          i;
        for (i = 0; i < nbytes; i += 3)
        begin
            grp = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255))};
            if (i + 1 >= nbytes)
            begin
                grp[15:0] = '0;
            end
            else if (i + 2 >= nbytes)
            begin
                grp[7:0] = '0;
            end
            txt.insert(txt.size(), sextet_char(grp[23:18]));
            txt.insert(txt.size(), sextet_char(grp[17:12]));
            if (i + 1 < nbytes)
            begin
                txt.insert(txt.size(), sextet_char(grp[11:6]));
            end
            else if (pad)
            begin
                txt.insert(txt.size(), "=");
            end
            if (i + 2 < nbytes)
            begin
                txt.insert(txt.size(), sextet_char(grp[5:0]));
            end
            else if (pad)
            begin
                txt.insert(txt.size(), "=");
            end
        end
        if (lone)
        begin
            txt.insert(txt.size(), sextet_char(6'($urandom_range(0, 63))));
        end
        if (damage && txt.size() > 0)
        begin
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        end
        repeat (tail)
        begin
            txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        if (txt.size() == 0)
        begin
            txt.insert(txt.size(), sextet_char(6'($urandom_range(0, 63))));
        end
        queue_text(txt);
    endtask

    // Mostly no gap or a short one, a few long ones, and now and then a stretch with none
    function automatic int gap_cycles(inout int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR cycle %0d: %s: expected %0h, got %0h",
                     cycle_count, what, want_v, got_v);
        end
    endtask

    // Character driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && !s_axis_tready)
            begin
                input_stall_cycles++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_char(s_axis_tdata, s_axis_tlast);
                chars_accepted++;
                if (s_axis_tlast)
                begin
                    strings_closed++;
                end
                src_wait = gap_cycles(src_burst);
                if (src_wait == 0 && text_queue.size() > 0)
                begin
                    {s_axis_tdata, s_axis_tlast} <= text_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            else if (!s_axis_tvalid)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                end
                else if (text_queue.size() > 0)
                begin
                    {s_axis_tdata, s_axis_tlast} <= text_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Byte monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte item with nothing expected", 8'h00, m_axis_tdata);
                end
                else
                begin
                    want_item = expected_bytes.pop_front();
                    bytes_checked++;
                    if (!want_item.valid)
                    begin
                        empty_ends++;
                    end
                    if (m_axis_tdata !== want_item.data)
                    begin
                        report_mismatch("out_byte", want_item.data, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want_item.valid)
                    begin
                        report_mismatch("byte_valid", want_item.valid, m_axis_tuser);
                    end
                    if (m_axis_tlast !== want_item.last)
                    begin
                        report_mismatch("last_of_text", want_item.last, m_axis_tlast);
                    end
                end
                snk_wait = gap_cycles(snk_burst);
            end
            if (snk_wait > 0)
            begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !sink_hold;
            end
        end
    end

    // Long output stall so that the internal queue fills and the input backs up
    initial
    begin
        wait (rst_n === 1'b1);
        while (chars_accepted < HOLD_AFTER)
        begin
            @(posedge clk);
        end
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d byte items still expected",
                     cycle_count, expected_bytes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] txt [$];
        int         kind;
        int         len;
        int         i;
        int         directed_chars;

        // Full group closed by the final character
        add_string("TWFu");
        // Padding after three values, then after two
        add_string("TWE=");
        add_string("TQ==");
        // Lone value at the end gives only the empty end item
        add_string("Q");
        // All-ones group
        add_string("////");
        // Out-of-alphabet byte halts; the final 'Z' is ignored
        txt = '{8'h5a, 8'h67, 8'hff, 8'h5a};
        queue_text(txt);
        // Halt on the very first character
        txt = '{8'h80, 8'h41};
        queue_text(txt);
        txt = '{8'h00};
        queue_text(txt);
        add_string("AA+9");
        directed_chars = queued_chars;

        while (queued_chars < directed_chars + RANDOM_CHARS)
        begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 9);
            if (kind < 60)
            begin
                add_encoded_text(len, $urandom_range(0, 1), 1'b0, 0, 1'b0);
            end
            else if (kind < 75)
            begin
                add_encoded_text(len, $urandom_range(0, 1), 1'b1, $urandom_range(0, 3), 1'b0);
            end
            else if (kind < 88)
            begin
                add_encoded_text(3 * $urandom_range(0, 3), 1'b0, 1'b0, 0, 1'b1);
            end
            else
            begin
                txt = {};
                for (i = 0; i < $urandom_range(1, 5); i++)
                begin
                    txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                end
                queue_text(txt);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (text_queue.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d strings, %0d characters; checked %0d byte items (%0d empty ends)",
                 strings_closed, chars_accepted, bytes_checked, empty_ends);
        $display("Input was held back for %0d cycles during output stalls",
                 input_stall_cycles);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
